// ===== src/diamond_square_heightmap_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap unit
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIAMOND_SQUARE_HEIGHTMAP_UNIT_DEFINES_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_UNIT_DEFINES_SVH

// same-cycle implication
`define DSH_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSH_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dsh_pkg.sv =====
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types and codes for the diamond-square heightmap unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsh_pkg;

    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_DONE  = 2'd3;

    localparam logic [1:0] CFG_GRID_LEVELS = 2'd0;
    localparam logic [1:0] CFG_ROUGHNESS   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT_GAIN = 2'd2;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SLAST,
        S_SCALC,
        S_SWR,
        S_SMIR,
        S_RRD,
        S_RMUL,
        S_RSAT,
        S_CORNER
    } state_t;

endpackage

// ===== src/dsh_ram.sv =====
// ----------------------------------------------------------------------------
// dsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1089
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/diamond_square_heightmap_unit.sv =====
// Diamond-square heightmap unit. Items are taken with start while busy is low;
// each item gives one result, shown for a single cycle on result_strobe, which
// the receiver must take as it comes. The grid lives in one RAM with one write
// and one registered read port, so a sample reads four neighbors one by one,
// combines them and writes the point, plus one more write for an edge copy;
// a read steps through read, multiply, saturate; a restart writes four corners;
// ignored or rejected items answer from idle. No clearing pass is run.
`timescale 1ns / 1ps
`include "diamond_square_heightmap_unit_defines.svh"

// ----------------------------------------------------------------------------
// diamond_square_heightmap_unit
// Fixed-point wrapping diamond-square terrain generator with scaled readout.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_unit #(
    parameter int MAX_LEVELS = 5,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [15:0]        random_fraction,
    input  logic [5:0]         read_x,
    input  logic [5:0]         read_y,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_wdata,
    output logic               result_strobe,
    output logic signed [31:0] height_out,
    output logic               generation_done,
    output logic [1:0]         status
);

    localparam int GSIDE = (1 << MAX_LEVELS) + 1;
    localparam int DEPTH = GSIDE * GSIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = MAX_LEVELS + 1;
    localparam int LW    = $clog2(MAX_LEVELS + 1);
    localparam int CMPW  = ((CW > 6) ? CW : 6) + 1;
    localparam int RST_LEVELS = (5 > MAX_LEVELS) ? MAX_LEVELS : 5;

    // configuration
    logic [2:0]         grid_levels_reg;
    logic [16:0]        roughness_ratio_reg;
    logic signed [31:0] height_gain_reg;

    // generator state
    dsh_pkg::state_t    state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]      cursor_x_reg, cursor_x_next;
    logic [CW-1:0]      cursor_y_reg, cursor_y_next;
    logic [CW-1:0]      step_size_reg, step_size_next;
    logic               diamond_phase_reg, diamond_phase_next;
    logic               odd_row_reg, odd_row_next;
    logic [16:0]        noise_scale_reg, noise_scale_next;
    logic               done_flag_reg, done_flag_next;
    logic [LW-1:0]      gen_levels_reg, gen_levels_next;

    // datapath
    logic signed [35:0] noise_reg, noise_next;
    logic signed [33:0] sum_reg, sum_next;
    logic signed [31:0] value_reg, value_next;
    logic [AW-1:0]      mirror_addr_reg, mirror_addr_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [CW-1:0]      rd_x_reg, rd_x_next;
    logic [CW-1:0]      rd_y_reg, rd_y_next;

    // result
    logic               strobe_reg, strobe_next;
    logic signed [31:0] height_reg, height_next;
    logic [1:0]         status_reg, status_next;

    // memory ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(AW'(x) * AW'(GSIDE) + AW'(y));
    endfunction

    function automatic logic [LW-1:0] clamp_levels(input logic [2:0] lv);
        logic [LW-1:0] r;
        if (lv == 3'd0)
        begin
            r = LW'(1);
        end
        else if (int'(lv) > MAX_LEVELS)
        begin
            r = LW'(MAX_LEVELS);
        end
        else
        begin
            r = LW'(lv);
        end
        return r;
    endfunction

    dsh_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------------
    // common combinational terms
    // ------------------------------------------------------------------------
    logic               accept;
    logic [CW-1:0]      sm;
    logic [CW:0]        two_j;
    logic [CW:0]        y_plus2j;
    logic [CW:0]        x_plus2j;
    logic [CW-1:0]      x_plusj;
    logic [LW-1:0]      new_levels;
    logic [CW-1:0]      new_sm;
    logic [16:0]        ratio_clamped;
    logic [33:0]        scale_prod;
    logic [CMPW-1:0]    side_cmp;
    logic [CMPW-1:0]    rx_cmp;
    logic [CMPW-1:0]    ry_cmp;
    logic signed [17:0] r_centered;
    logic signed [35:0] noise_prod;
    logic signed [36:0] value_wide;
    logic signed [63:0] prod_shifted;
    logic [CW-1:0]      nb_x;
    logic [CW-1:0]      nb_y;

    assign accept        = start && (state_reg == dsh_pkg::S_IDLE);
    assign sm            = CW'(1) << gen_levels_reg;
    assign two_j         = {step_size_reg, 1'b0};
    assign y_plus2j      = (CW + 1)'(cursor_y_reg) + two_j;
    assign x_plus2j      = (CW + 1)'(cursor_x_reg) + two_j;
    assign x_plusj       = cursor_x_reg + step_size_reg;
    assign new_levels    = clamp_levels(grid_levels_reg);
    assign new_sm        = CW'(1) << new_levels;
    assign ratio_clamped = (roughness_ratio_reg > dsh_pkg::ONE_Q16) ? dsh_pkg::ONE_Q16
                                                                  : roughness_ratio_reg;
    assign scale_prod    = noise_scale_reg * ratio_clamped;
    assign side_cmp      = CMPW'(sm) + CMPW'(1);
    assign rx_cmp        = CMPW'(read_x);
    assign ry_cmp        = CMPW'(read_y);
    assign r_centered    = $signed({2'b00, random_fraction}) - 18'sd32768;
    assign noise_prod    = r_centered * $signed({1'b0, noise_scale_reg});
    assign value_wide    = 37'(sum_reg >>> 2) + 37'(noise_reg);
    assign prod_shifted  = prod_reg >>> FRAC_BITS;

    // neighbor coordinates for the read in flight
    always_comb
    begin
        nb_x = cursor_x_reg;
        nb_y = cursor_y_reg;
        if (!diamond_phase_reg)
        begin
            nb_x = cnt_reg[0] ? cursor_x_reg + step_size_reg : cursor_x_reg - step_size_reg;
            nb_y = cnt_reg[1] ? cursor_y_reg + step_size_reg : cursor_y_reg - step_size_reg;
        end
        else
        begin
            case (cnt_reg)
                2'd0:
                begin
                    nb_y = (cursor_y_reg == '0) ? sm - step_size_reg
                                                : cursor_y_reg - step_size_reg;
                end
                2'd1:
                begin
                    nb_x = x_plusj;
                end
                2'd2:
                begin
                    nb_x = (cursor_x_reg == '0) ? sm - step_size_reg
                                                : cursor_x_reg - step_size_reg;
                end
                default:
                begin
                    nb_y = cursor_y_reg + step_size_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsh_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        dsh_pkg::FUNC_SAMPLE:
                        begin
                            if (!done_flag_reg && step_size_reg != '0)
                            begin
                                state_next = dsh_pkg::S_SRD;
                            end
                        end
                        dsh_pkg::FUNC_READ:
                        begin
                            if (done_flag_reg && rx_cmp < side_cmp && ry_cmp < side_cmp)
                            begin
                                state_next = dsh_pkg::S_RRD;
                            end
                        end
                        dsh_pkg::FUNC_RESTART:
                        begin
                            state_next = dsh_pkg::S_CORNER;
                        end
                        default:
                        begin
                            state_next = dsh_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dsh_pkg::S_SRD:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = dsh_pkg::S_SLAST;
                end
            end
            dsh_pkg::S_SLAST:  state_next = dsh_pkg::S_SCALC;
            dsh_pkg::S_SCALC:  state_next = dsh_pkg::S_SWR;
            dsh_pkg::S_SWR:
            begin
                if (diamond_phase_reg && (cursor_x_reg == '0 || cursor_y_reg == '0))
                begin
                    state_next = dsh_pkg::S_SMIR;
                end
                else
                begin
                    state_next = dsh_pkg::S_IDLE;
                end
            end
            dsh_pkg::S_SMIR:   state_next = dsh_pkg::S_IDLE;
            dsh_pkg::S_RRD:    state_next = dsh_pkg::S_RMUL;
            dsh_pkg::S_RMUL:   state_next = dsh_pkg::S_RSAT;
            dsh_pkg::S_RSAT:   state_next = dsh_pkg::S_IDLE;
            dsh_pkg::S_CORNER:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = dsh_pkg::S_IDLE;
                end
            end
            default:           state_next = dsh_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs and datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        cnt_next           = cnt_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        step_size_next     = step_size_reg;
        diamond_phase_next = diamond_phase_reg;
        odd_row_next       = odd_row_reg;
        noise_scale_next   = noise_scale_reg;
        done_flag_next     = done_flag_reg;
        gen_levels_next    = gen_levels_reg;
        noise_next         = noise_reg;
        sum_next           = sum_reg;
        value_next         = value_reg;
        mirror_addr_next   = mirror_addr_reg;
        prod_next          = prod_reg;
        rd_x_next          = rd_x_reg;
        rd_y_next          = rd_y_reg;
        strobe_next        = 1'b0;
        height_next        = height_reg;
        status_next        = status_reg;
        mem_we             = 1'b0;
        mem_waddr          = addr_of(cursor_x_reg, cursor_y_reg);
        mem_wdata          = value_reg;
        mem_raddr          = addr_of(nb_x, nb_y);

        case (state_reg)
            dsh_pkg::S_IDLE:
            begin
                cnt_next = 2'd0;
                if (accept)
                begin
                    height_next = '0;
                    status_next = dsh_pkg::ST_OK;
                    noise_next  = noise_prod >>> (32 - FRAC_BITS);
                    rd_x_next   = rx_cmp[CW-1:0];
                    rd_y_next   = ry_cmp[CW-1:0];
                    case (func)
                        dsh_pkg::FUNC_SAMPLE:
                        begin
                            if (done_flag_reg || step_size_reg == '0)
                            begin
                                status_next = dsh_pkg::ST_IGNORED;
                                strobe_next = 1'b1;
                            end
                        end
                        dsh_pkg::FUNC_READ:
                        begin
                            if (!done_flag_reg)
                            begin
                                status_next = dsh_pkg::ST_NOT_DONE;
                                strobe_next = 1'b1;
                            end
                            else if (rx_cmp >= side_cmp || ry_cmp >= side_cmp)
                            begin
                                status_next = dsh_pkg::ST_RANGE;
                                strobe_next = 1'b1;
                            end
                        end
                        dsh_pkg::FUNC_RESTART:
                        begin
                            gen_levels_next    = new_levels;
                            step_size_next     = new_sm >> 1;
                            cursor_x_next      = new_sm >> 1;
                            cursor_y_next      = new_sm >> 1;
                            noise_scale_next   = ratio_clamped;
                            diamond_phase_next = 1'b0;
                            odd_row_next       = 1'b0;
                            done_flag_next     = 1'b0;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            dsh_pkg::S_SRD:
            begin
                cnt_next = cnt_reg + 2'd1;
                sum_next = (cnt_reg == 2'd0) ? '0 : sum_reg + 34'(signed'(mem_rdata));
            end
            dsh_pkg::S_SLAST:
            begin
                sum_next = sum_reg + 34'(signed'(mem_rdata));
            end
            dsh_pkg::S_SCALC:
            begin
                if (value_wide > 37'sd2147483647)
                begin
                    value_next = 32'sh7FFFFFFF;
                end
                else if (value_wide < -37'sd2147483648)
                begin
                    value_next = 32'sh80000000;
                end
                else
                begin
                    value_next = value_wide[31:0];
                end
            end
            dsh_pkg::S_SWR:
            begin
                mem_we = 1'b1;
                mirror_addr_next = (cursor_x_reg == '0) ? addr_of(sm, cursor_y_reg)
                                                        : addr_of(cursor_x_reg, sm);
                if (!(diamond_phase_reg && (cursor_x_reg == '0 || cursor_y_reg == '0)))
                begin
                    strobe_next = 1'b1;
                end
                // walk to the next point
                if (!diamond_phase_reg)
                begin
                    if (y_plus2j >= (CW + 1)'(sm))
                    begin
                        cursor_y_next = step_size_reg;
                        if (x_plus2j >= (CW + 1)'(sm))
                        begin
                            diamond_phase_next = 1'b1;
                            odd_row_next       = 1'b1;
                            cursor_x_next      = '0;
                        end
                        else
                        begin
                            cursor_x_next = x_plus2j[CW-1:0];
                        end
                    end
                    else
                    begin
                        cursor_y_next = y_plus2j[CW-1:0];
                    end
                end
                else if (y_plus2j < (CW + 1)'(sm))
                begin
                    cursor_y_next = y_plus2j[CW-1:0];
                end
                else if (x_plusj < sm)
                begin
                    cursor_x_next = x_plusj;
                    odd_row_next  = !odd_row_reg;
                    cursor_y_next = odd_row_reg ? '0 : step_size_reg;
                end
                else
                begin
                    step_size_next     = step_size_reg >> 1;
                    diamond_phase_next = 1'b0;
                    odd_row_next       = 1'b0;
                    if ((step_size_reg >> 1) == '0)
                    begin
                        done_flag_next = 1'b1;
                        cursor_x_next  = '0;
                        cursor_y_next  = '0;
                    end
                    else
                    begin
                        noise_scale_next = scale_prod[32:16];
                        cursor_x_next    = step_size_reg >> 1;
                        cursor_y_next    = step_size_reg >> 1;
                    end
                end
            end
            dsh_pkg::S_SMIR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = mirror_addr_reg;
                strobe_next = 1'b1;
            end
            dsh_pkg::S_RRD:
            begin
                mem_raddr = addr_of(rd_x_reg, rd_y_reg);
            end
            dsh_pkg::S_RMUL:
            begin
                prod_next = signed'(mem_rdata) * height_gain_reg;
            end
            dsh_pkg::S_RSAT:
            begin
                strobe_next = 1'b1;
                if (prod_shifted > 64'sd2147483647)
                begin
                    height_next = 32'sh7FFFFFFF;
                end
                else if (prod_shifted < -64'sd2147483648)
                begin
                    height_next = 32'sh80000000;
                end
                else
                begin
                    height_next = prod_shifted[31:0];
                end
            end
            dsh_pkg::S_CORNER:
            begin
                cnt_next  = cnt_reg + 2'd1;
                mem_we    = 1'b1;
                mem_wdata = '0;
                mem_waddr = addr_of(cnt_reg[0] ? sm : '0, cnt_reg[1] ? sm : '0);
                if (cnt_reg == 2'd3)
                begin
                    strobe_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_levels_reg     <= 3'd5;
            roughness_ratio_reg <= 17'd32768;
            height_gain_reg     <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                dsh_pkg::CFG_GRID_LEVELS: grid_levels_reg     <= cfg_wdata[2:0];
                dsh_pkg::CFG_ROUGHNESS:   roughness_ratio_reg <= cfg_wdata[16:0];
                dsh_pkg::CFG_HEIGHT_GAIN: height_gain_reg     <= signed'(cfg_wdata);
                default:                  grid_levels_reg     <= grid_levels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= dsh_pkg::S_IDLE;
            cnt_reg           <= '0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            step_size_reg     <= '0;
            diamond_phase_reg <= 1'b0;
            odd_row_reg       <= 1'b0;
            noise_scale_reg   <= dsh_pkg::ONE_Q16;
            done_flag_reg     <= 1'b0;
            gen_levels_reg    <= LW'(RST_LEVELS);
            strobe_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            step_size_reg     <= step_size_next;
            diamond_phase_reg <= diamond_phase_next;
            odd_row_reg       <= odd_row_next;
            noise_scale_reg   <= noise_scale_next;
            done_flag_reg     <= done_flag_next;
            gen_levels_reg    <= gen_levels_next;
            strobe_reg        <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg       <= noise_next;
        sum_reg         <= sum_next;
        value_reg       <= value_next;
        mirror_addr_reg <= mirror_addr_next;
        prod_reg        <= prod_next;
        rd_x_reg        <= rd_x_next;
        rd_y_reg        <= rd_y_next;
        height_reg      <= height_next;
        status_reg      <= status_next;
    end

    assign busy            = (state_reg != dsh_pkg::S_IDLE);
    assign result_strobe   = strobe_reg;
    assign height_out      = height_reg;
    assign status          = status_reg;
    assign generation_done = done_flag_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `DSH_ASSERT_IMP(a_strobe_idle, strobe_reg, state_reg == dsh_pkg::S_IDLE, "result while busy")
    `DSH_ASSERT_IMP(a_done_step, done_flag_reg, step_size_reg == '0, "done with nonzero step")
    `DSH_ASSERT_IMP(a_we_state, mem_we, state_reg == dsh_pkg::S_SWR || state_reg == dsh_pkg::S_SMIR || state_reg == dsh_pkg::S_CORNER, "grid write outside a write state")
    `DSH_ASSERT_NXT(a_corner_end, state_reg == dsh_pkg::S_CORNER && cnt_reg == 2'd3, strobe_reg && !done_flag_reg, "restart result missing")

endmodule

// ===== tb/tb_diamond_square_heightmap_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diamond_square_heightmap_unit
// Self-checking bench: drives restart/sample/read and unused-code items with
// random gaps, predicts every result from its own fixed-point terrain model and compares.
// ----------------------------------------------------------------------------

typedef struct {
    logic [31:0] height;
    logic        done;
    logic [1:0]  stat;
} terrain_result_t;

class terrain_scoreboard;
    localparam int GS = 33;
    localparam int LVL_MAX = 5;

    int          grid [GS][GS];
    int          cur_x, cur_y, step, sm;
    bit          diamond, odd;
    longint      nscale;
    bit          done_f;
    int          lat_levels;
    int          reg_levels;
    longint      reg_ratio;
    logic [31:0] reg_gain;
    terrain_result_t pending_q[$];
    bit          failed;

    function new();
        foreach (grid[i, j]) grid[i][j] = 0;
        cur_x = 0; cur_y = 0; step = 0; diamond = 0; odd = 0;
        nscale = 65536; done_f = 0;
        reg_levels = 5; reg_ratio = 32768; reg_gain = 32'd65536;
        lat_levels = 5; sm = 32;
        failed = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        if (idx == dsh_pkg::CFG_GRID_LEVELS) reg_levels = int'(data[2:0]);
        else if (idx == dsh_pkg::CFG_ROUGHNESS) reg_ratio = longint'(data[16:0]);
        else if (idx == dsh_pkg::CFG_HEIGHT_GAIN) reg_gain = data;
    endfunction

    function longint ratio_eff();
        return (reg_ratio > 65536) ? 65536 : reg_ratio;
    endfunction

    // out-of-grid coordinates alias to the origin entry
    function longint cell_at(int x, int y);
        if (x < 0 || x >= GS || y < 0 || y >= GS) return grid[0][0];
        return grid[x][y];
    endfunction

    function void cell_set(int x, int y, int v);
        if (x < 0 || x >= GS || y < 0 || y >= GS) grid[0][0] = v;
        else grid[x][y] = v;
    endfunction

    function int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function void step_cursor();
        int j;
        j = step;
        if (!diamond) begin
            cur_y += 2 * j;
            if (cur_y >= sm) begin
                cur_y = j;
                cur_x += 2 * j;
                if (cur_x >= sm) begin
                    diamond = 1; odd = 1; cur_x = 0; cur_y = j;
                end
            end
            return;
        end
        cur_y += 2 * j;
        if (cur_y < sm) return;
        cur_x += j;
        if (cur_x < sm) begin
            odd = !odd;
            cur_y = odd ? j : 0;
            return;
        end
        step = j >> 1;
        diamond = 0; odd = 0;
        if (step == 0) begin
            done_f = 1; cur_x = 0; cur_y = 0;
            return;
        end
        nscale = (nscale * ratio_eff()) >> 16;
        cur_x = step; cur_y = step;
    endfunction

    function void make_point(logic [15:0] r);
        int     x, y, j, v;
        longint sum, noise;
        x = cur_x; y = cur_y; j = step;
        if (!diamond)
            sum = cell_at(x - j, y - j) + cell_at(x + j, y - j)
                + cell_at(x - j, y + j) + cell_at(x + j, y + j);
        else if (x == 0)
            sum = cell_at(x, y - j) + cell_at(x + j, y) + cell_at(sm - j, y) + cell_at(x, y + j);
        else if (y == 0)
            sum = cell_at(x, sm - j) + cell_at(x + j, y) + cell_at(x - j, y) + cell_at(x, y + j);
        else
            sum = cell_at(x, y - j) + cell_at(x + j, y) + cell_at(x - j, y) + cell_at(x, y + j);
        noise = ((longint'(r) - 32768) * nscale) >>> 16;
        v = sat32((sum >>> 2) + noise);
        cell_set(x, y, v);
        if (diamond) begin
            if (x == 0) cell_set(sm, y, v);
            if (y == 0) cell_set(x, sm, v);
        end
        step_cursor();
    endfunction

    function void note_item(logic [1:0] f, logic [15:0] r, logic [5:0] rx, logic [5:0] ry);
        terrain_result_t e;
        longint gain;
        e.height = '0; e.stat = dsh_pkg::ST_OK;
        if (f == dsh_pkg::FUNC_SAMPLE) begin
            if (done_f || step == 0) e.stat = dsh_pkg::ST_IGNORED;
            else make_point(r);
        end else if (f == dsh_pkg::FUNC_READ) begin
            if (!done_f) e.stat = dsh_pkg::ST_NOT_DONE;
            else if (int'(rx) > sm || int'(ry) > sm) e.stat = dsh_pkg::ST_RANGE;
            else begin
                gain = longint'($signed(reg_gain));
                e.height = sat32((cell_at(int'(rx), int'(ry)) * gain) >>> 16);
            end
        end else if (f == dsh_pkg::FUNC_RESTART) begin
            lat_levels = (reg_levels < 1) ? 1 : (reg_levels > LVL_MAX) ? LVL_MAX : reg_levels;
            sm = 1 << lat_levels;
            cell_set(0, 0, 0); cell_set(0, sm, 0); cell_set(sm, 0, 0); cell_set(sm, sm, 0);
            step = sm >> 1;
            nscale = (65536 * ratio_eff()) >> 16;
            diamond = 0; odd = 0;
            cur_x = step; cur_y = step;
            done_f = 0;
        end
        e.done = done_f;
        pending_q.push_back(e);
    endfunction

    function void check_result(logic [31:0] h, logic d, logic [1:0] s);
        terrain_result_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result height=%h done=%b status=%0d", $time, h, d, s);
            failed = 1;
            return;
        end
        e = pending_q.pop_front();
        if (h !== e.height) begin
            $display("%0t: height_out expected %h actual %h", $time, e.height, h);
            failed = 1;
        end
        if (d !== e.done) begin
            $display("%0t: generation_done expected %b actual %b", $time, e.done, d);
            failed = 1;
        end
        if (s !== e.stat) begin
            $display("%0t: status expected %0d actual %0d", $time, e.stat, s);
            failed = 1;
        end
    endfunction
endclass

module tb_diamond_square_heightmap_unit;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         func;
    logic [15:0]        random_fraction;
    logic [5:0]         read_x;
    logic [5:0]         read_y;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [31:0]        cfg_wdata;
    logic               result_strobe;
    logic signed [31:0] height_out;
    logic               generation_done;
    logic [1:0]         status;

    terrain_scoreboard sb;
    int  items_sent;
    bit  no_gaps;

    diamond_square_heightmap_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .random_fraction (random_fraction),
        .read_x          (read_x),
        .read_y          (read_y),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_wdata       (cfg_wdata),
        .result_strobe   (result_strobe),
        .height_out      (height_out),
        .generation_done (generation_done),
        .status          (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_result(height_out, generation_done, status);
    end

    function int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 65) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge; returns after acceptance and any random gap after it
    task automatic send_item(logic [1:0] f, logic [15:0] r, logic [5:0] x, logic [5:0] y);
        int g;
        start <= 1'b1;
        func <= f;
        random_fraction <= r;
        read_x <= x;
        read_y <= y;
        do @(posedge clk); while (busy);
        sb.note_item(f, r, x, y);
        items_sent++;
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() > 0) @(posedge clk);
        while (busy) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // writes the register, then drops the enable and idles before returning
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function logic [15:0] rand_frac();
        int p;
        p = $urandom_range(0, 15);
        if (p == 0) return 16'h0000;
        if (p == 1) return 16'hffff;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic read_some(int n, int side);
        logic [5:0] x, y;
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                x = 6'($urandom_range(0, 63));
                y = 6'($urandom_range(side - 1, 63));
                if ($urandom_range(0, 1)) {x, y} = {y, x};
            end
            else
            begin
                x = 6'($urandom_range(0, side - 1));
                y = 6'($urandom_range(0, side - 1));
            end
            send_item(dsh_pkg::FUNC_READ, 16'($urandom), x, y);
        end
    endtask

    // one terrain: configure, restart, generate with some noise, then read back
    task automatic run_terrain(logic [2:0] lv, logic [16:0] ratio, logic [31:0] gain,
                               bit broken);
        int eff, side, npts, k;
        write_reg(dsh_pkg::CFG_GRID_LEVELS, {29'd0, lv});
        write_reg(dsh_pkg::CFG_ROUGHNESS, {15'd0, ratio});
        write_reg(dsh_pkg::CFG_HEIGHT_GAIN, gain);
        eff = (lv < 3'd1) ? 1 : (lv > 3'd5) ? 5 : int'(lv);
        side = (1 << eff) + 1;
        npts = side * side - 4;
        send_item(dsh_pkg::FUNC_RESTART, 16'($urandom), 6'($urandom), 6'($urandom));
        if (broken)
        begin
            repeat ($urandom_range(1, npts - 1))
                send_item(dsh_pkg::FUNC_SAMPLE, rand_frac(), 6'($urandom), 6'($urandom));
            send_item(dsh_pkg::FUNC_READ, 16'($urandom), 6'd0, 6'd0);
            send_item(dsh_pkg::FUNC_RESTART, 16'($urandom), 6'($urandom), 6'($urandom));
        end
        k = 0;
        while (k < npts)
        begin
            case ($urandom_range(0, 39))
                0: send_item(dsh_pkg::FUNC_READ, 16'($urandom), 6'($urandom), 6'($urandom));
                1: send_item(FUNC_UNUSED, 16'($urandom), 6'($urandom), 6'($urandom));
                default:
                begin
                    send_item(dsh_pkg::FUNC_SAMPLE, rand_frac(), 6'($urandom), 6'($urandom));
                    k++;
                end
            endcase
        end
        send_item(dsh_pkg::FUNC_SAMPLE, rand_frac(), 6'($urandom), 6'($urandom));
        send_item(dsh_pkg::FUNC_READ, 16'($urandom), 6'(side - 1), 6'(side - 1));
        send_item(dsh_pkg::FUNC_READ, 16'($urandom), 6'(side), 6'd0);
        send_item(dsh_pkg::FUNC_READ, 16'($urandom), 6'd0, 6'd63);
        read_some($urandom_range(8, 25), side);
        drain();
    endtask

    initial
    begin
        logic [2:0]  lv;
        logic [16:0] ratio;
        logic [31:0] gain;
        int p;
        sb = new();
        items_sent = 0;
        no_gaps = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = dsh_pkg::FUNC_SAMPLE;
        random_fraction = '0;
        read_x = '0;
        read_y = '0;
        cfg_we = 1'b0;
        cfg_idx = dsh_pkg::CFG_GRID_LEVELS;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing armed yet
        send_item(dsh_pkg::FUNC_SAMPLE, 16'hffff, 6'd0, 6'd0);
        send_item(dsh_pkg::FUNC_READ, 16'h0000, 6'd63, 6'd63);
        send_item(FUNC_UNUSED, 16'hffff, 6'd63, 6'd63);
        drain();

        // level count above the limit: partial run, done must stay low
        write_reg(dsh_pkg::CFG_GRID_LEVELS, 32'd7);
        send_item(dsh_pkg::FUNC_RESTART, 16'($urandom), 6'($urandom), 6'($urandom));
        repeat (40)
            send_item(dsh_pkg::FUNC_SAMPLE, rand_frac(), 6'($urandom), 6'($urandom));
        send_item(dsh_pkg::FUNC_READ, 16'($urandom), 6'd0, 6'd0);
        drain();

        run_terrain(3'd1, 17'd0, 32'h7fffffff, 0);
        run_terrain(3'd0, 17'd65536, 32'h80000000, 0);
        run_terrain(3'd2, 17'h1ffff, 32'h00000000, 0);

        while (items_sent < 800)
        begin
            p = $urandom_range(0, 99);
            if (p < 50) lv = 3'd1;
            else if (p < 82) lv = 3'd2;
            else if (p < 92) lv = 3'd3;
            else if (p < 97) lv = 3'd0;
            else lv = 3'd4;
            ratio = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65536, 131071))
                                                : 17'($urandom_range(0, 65536));
            p = $urandom_range(0, 9);
            if (p == 0) gain = 32'h7fffffff;
            else if (p == 1) gain = 32'h80000000;
            else if (p < 6) gain = $urandom;
            else gain = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            no_gaps = ($urandom_range(0, 4) == 0);
            run_terrain(lv, ratio, gain, $urandom_range(0, 5) == 0);
        end

        if (sb.failed == 0 && sb.pending_q.size() == 0)
            $display("[diamond_square_heightmap_unit] OK");
        else
            $display("[diamond_square_heightmap_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[diamond_square_heightmap_unit] ERROR");
        $finish;
    end
endmodule
